@@ hdl/bta_pkg.sv @@
// Shared types and constants for the block table heap allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package bta_pkg;

  // Heap geometry.
  localparam int unsigned MAX_BLOCKS_DEF = 1024;
  localparam int unsigned BLOCK_BYTES    = 4096;
  localparam int unsigned BLOCK_SHIFT    = $clog2(BLOCK_BYTES);

  // Field widths.
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned BYTES_W  = 32;
  localparam int unsigned BIU_W    = 11;
  localparam int unsigned S_DATA_W = 64;
  localparam int unsigned M_DATA_W = 32;
  localparam int unsigned NEED_W   = BYTES_W + 1 - BLOCK_SHIFT;

  localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(1024);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Map entry bit positions.
  localparam int unsigned ENT_TAKEN = 0;
  localparam int unsigned ENT_FIRST = 1;
  localparam int unsigned ENT_NEXT  = 2;
  localparam int unsigned ENT_W     = 3;

  typedef struct packed {
    logic clear;        // reset sweep, one entry per cycle
    logic accept;       // take the input word
    logic scan;         // first-fit scan step
    logic mark;         // write one entry of the granted run
    logic free;         // free chain step
    logic set_fail;     // allocate found no run
    logic load;         // load the output register
  } bta_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic op_free;
    logic alloc_reject;
    logic free_reject;
    logic found;
    logic exhausted;
    logic mark_last;
    logic free_done;
    logic out_free;
  } bta_status_t;

endpackage
`default_nettype wire

@@ hdl/bta_ctrl.sv @@
// Sequencing state machine for the block table heap allocator.
// Depends on bta_pkg for the command and status structs.
`default_nettype none
module bta_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  bta_pkg::bta_status_t status_i,
  output bta_pkg::bta_cmd_t    cmd_o
);
  import bta_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_MARK  = 6'b001000,
    ST_FREE  = 6'b010000,
    ST_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.op_free) begin
            state_d = status_i.free_reject ? ST_RESP : ST_FREE;
          end else begin
            state_d = status_i.alloc_reject ? ST_RESP : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.found) begin
          state_d = ST_MARK;
        end else if (status_i.exhausted) begin
          cmd_o.set_fail = 1'b1;
          state_d        = ST_RESP;
        end
      end
      ST_MARK: begin
        cmd_o.mark = 1'b1;
        if (status_i.mark_last) begin
          state_d = ST_RESP;
        end
      end
      ST_FREE: begin
        cmd_o.free = 1'b1;
        if (status_i.free_done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/bta_dpath.sv @@
// Datapath of the block table heap allocator: configuration registers,
// block map memory, scan and free pointers, and the output register.
// Depends on bta_pkg.
`default_nettype none
module bta_dpath #(
  parameter int unsigned MAX_BLOCKS = bta_pkg::MAX_BLOCKS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  input  wire [bta_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [31:0]                         cfg_data_i,
  input  wire [bta_pkg::S_DATA_W-1:0]        in_data_i,
  input  wire                                in_op_i,
  output logic [bta_pkg::M_DATA_W-1:0]       out_data_o,
  output logic                               out_status_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  input  bta_pkg::bta_cmd_t                  cmd_i,
  output bta_pkg::bta_status_t               status_o
);
  import bta_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  logic [ADDR_W-1:0] heap_base_q;
  logic [BIU_W-1:0]  biu_q;

  logic [ENT_W-1:0]  map_mem [MAX_BLOCKS];
  logic [ENT_W-1:0]  rd_data_q;

  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  run_q, run_d;
  logic [IDX_W-1:0]  start_q, start_d;
  logic [CNT_W-1:0]  need_q, need_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic              fail_q, fail_d;
  logic              op_free_q, op_free_d;

  logic [ADDR_W-1:0] out_addr_q;
  logic              out_status_q, out_vld_q;

  logic [31:0]        lim_w;
  logic [CNT_W-1:0]   limit;
  logic [BYTES_W:0]   bytes_sum;
  logic [NEED_W-1:0]  need_full;
  logic [ADDR_W-1:0]  free_addr, free_off, free_blk;
  logic               free_ok;
  logic               issue;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENT_W-1:0]   wr_data;
  logic [ENT_W-1:0]   mark_ent;
  logic [CNT_W-1:0]   run_inc;
  logic [IDX_W-1:0]   mark_idx;

  // Table size saturates at the memory depth.
  assign lim_w = (32'(biu_q) > 32'(MAX_BLOCKS)) ? 32'(MAX_BLOCKS) : 32'(biu_q);
  assign limit = CNT_W'(lim_w);

  // Blocks needed, rounded up.
  assign bytes_sum = {1'b0, in_data_i[BYTES_W-1:0]} + (BYTES_W + 1)'(BLOCK_BYTES - 1);
  assign need_full = NEED_W'(bytes_sum >> BLOCK_SHIFT);

  assign free_addr = in_data_i[S_DATA_W-1:BYTES_W];
  assign free_off  = free_addr - heap_base_q;
  assign free_blk  = free_off >> BLOCK_SHIFT;
  assign free_ok   = (free_addr >= heap_base_q) && (free_blk < 32'(limit));

  assign issue    = (cmd_i.scan || cmd_i.free) && (ptr_q < limit);
  assign run_inc  = run_q + CNT_W'(1);
  assign mark_idx = start_q + k_q[IDX_W-1:0];

  always_comb begin
    mark_ent            = '0;
    mark_ent[ENT_TAKEN] = 1'b1;
    mark_ent[ENT_FIRST] = (k_q == '0);
    mark_ent[ENT_NEXT]  = ((k_q + CNT_W'(1)) != need_q);
  end

  assign status_o.clear_done   = (ptr_q == CNT_W'(MAX_BLOCKS - 1));
  assign status_o.op_free      = (in_op_i == OP_FREE);
  assign status_o.alloc_reject = (need_full == '0) ||
                                 ((NEED_W + CNT_W)'(need_full) > (NEED_W + CNT_W)'(limit));
  assign status_o.free_reject  = !free_ok;
  assign status_o.found        = rd_vld_q && !rd_data_q[ENT_TAKEN] && (run_inc == need_q);
  assign status_o.exhausted    = !rd_vld_q && !(ptr_q < limit);
  assign status_o.mark_last    = ((k_q + CNT_W'(1)) == need_q);
  assign status_o.free_done    = rd_vld_q && (!rd_data_q[ENT_NEXT] || !(ptr_q < limit));
  assign status_o.out_free     = !out_vld_q || out_ready_i;

  // Datapath control registers.
  always_comb begin
    ptr_d     = ptr_q;
    rd_vld_d  = rd_vld_q;
    rd_idx_d  = rd_idx_q;
    run_d     = run_q;
    start_d   = start_q;
    need_d    = need_q;
    k_d       = k_q;
    fail_d    = fail_q;
    op_free_d = op_free_q;

    if (cmd_i.clear) begin
      ptr_d = ptr_q + CNT_W'(1);
    end

    if (cmd_i.accept) begin
      rd_vld_d  = 1'b0;
      run_d     = '0;
      k_d       = '0;
      op_free_d = (in_op_i == OP_FREE);
      fail_d    = (in_op_i == OP_ALLOC) && status_o.alloc_reject;
      need_d    = CNT_W'(need_full);
      ptr_d     = (in_op_i == OP_FREE) ? CNT_W'(free_blk) : '0;
    end

    if (cmd_i.scan || cmd_i.free) begin
      rd_vld_d = issue;
      rd_idx_d = ptr_q[IDX_W-1:0];
      if (issue) begin
        ptr_d = ptr_q + CNT_W'(1);
      end
    end

    if (cmd_i.scan && rd_vld_q) begin
      if (rd_data_q[ENT_TAKEN]) begin
        run_d = '0;
      end else begin
        run_d = run_inc;
        if (run_q == '0) begin
          start_d = rd_idx_q;
        end
      end
    end

    if (cmd_i.mark) begin
      k_d = k_q + CNT_W'(1);
    end

    if (cmd_i.set_fail) begin
      fail_d = 1'b1;
    end
  end

  // One write port: reset sweep, run marking or chain clearing.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_q[IDX_W-1:0];
    wr_data = '0;
    if (cmd_i.clear) begin
      wr_en = 1'b1;
    end else if (cmd_i.mark) begin
      wr_en   = 1'b1;
      wr_addr = mark_idx;
      wr_data = mark_ent;
    end else if (cmd_i.free && rd_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_q <= map_mem[ptr_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      biu_q       <= BIU_RESET;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      fail_q      <= 1'b0;
      op_free_q   <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_HEAP_BASE) begin
          heap_base_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_BLOCKS_IN_USE) begin
          biu_q <= cfg_data_i[BIU_W-1:0];
        end
      end
      ptr_q     <= ptr_d;
      rd_vld_q  <= rd_vld_d;
      fail_q    <= fail_d;
      op_free_q <= op_free_d;
      if (cmd_i.load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    run_q    <= run_d;
    start_q  <= start_d;
    need_q   <= need_d;
    k_q      <= k_d;
    if (cmd_i.load) begin
      out_status_q <= !op_free_q && fail_q;
      out_addr_q   <= (op_free_q || fail_q) ? '0 :
                      heap_base_q + (ADDR_W'(start_q) << BLOCK_SHIFT);
    end
  end

  assign out_data_o   = out_addr_q;
  assign out_status_o = out_status_q;
  assign out_valid_o  = out_vld_q;

endmodule
`default_nettype wire

@@ hdl/block_table_heap_allocator.sv @@
// First-fit block table heap allocator, one request at a time.
// Allocate: a first-fit scan of the table, then one map write per block of the run; free:
// one map write per cleared entry of the chain; a rejected request goes straight to the
// result step. The single map memory port serialises these steps, and the result step waits
// while the previous word is unread. After reset a sweep zeroes all MAX_BLOCKS map entries;
// s_axis_tready stays low until it ends. Configuration writes are taken at any time.
`default_nettype none
module block_table_heap_allocator #(
  parameter int unsigned MAX_BLOCKS = bta_pkg::MAX_BLOCKS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [bta_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [31:0]                     cfg_data_i,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire [bta_pkg::S_DATA_W-1:0]    s_axis_tdata_i,  // request_bytes, free_address
  input  wire                            s_axis_tuser_i,  // operation
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  output logic [bta_pkg::M_DATA_W-1:0]   m_axis_tdata_o,  // address
  output logic                           m_axis_tuser_o   // status
);
  import bta_pkg::*;

  bta_cmd_t    cmd;
  bta_status_t status;

  assign cfg_ready_o = 1'b1;

  bta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bta_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata_i),
    .in_op_i      (s_axis_tuser_i),
    .out_data_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule
`default_nettype wire

@@ hdl/bta_checker.sv @@
// Port-level assertions for the block table heap allocator.
// Bound to block_table_heap_allocator; depends on bta_pkg for widths.
`default_nettype none
module bta_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          s_axis_tvalid_i,
  input wire                          s_axis_tready_o,
  input wire                          m_axis_tvalid_o,
  input wire                          m_axis_tready_i,
  input wire [bta_pkg::M_DATA_W-1:0]  m_axis_tdata_o,
  input wire                          m_axis_tuser_o
);
  import bta_pkg::*;

  logic       s_acc, m_acc;
  logic [1:0] pend_q;

  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc = m_axis_tvalid_o && m_axis_tready_i;

  // Words taken in but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (s_acc && !m_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (m_acc && !s_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("failed allocate with nonzero address");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("input taken while a request is in progress");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 2'd0)
    else $error("result without a pending request");

endmodule

bind block_table_heap_allocator bta_checker u_bta_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire

@@ sim/tb_block_table_heap_allocator.sv @@
// Self-checking testbench for block_table_heap_allocator: directed and random allocate and
// free requests, checked word by word against a first-fit block map kept in the testbench.
// Depends on bta_pkg and the block_table_heap_allocator RTL only.
module tb_block_table_heap_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import bta_pkg::*;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NO_MEMORY = 1'b1;
  localparam int unsigned FINAL_DRAIN_CYCLES = 20000;

  typedef struct {
    logic [ADDR_W-1:0] address;
    logic              status;
  } reply_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [31:0]           cfg_data_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [S_DATA_W-1:0]   s_axis_tdata_i;   // request_bytes, free_address
  logic                  s_axis_tuser_i;   // operation
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [M_DATA_W-1:0]   m_axis_tdata_o;   // address
  logic                  m_axis_tuser_o;   // status

  // Model of the block map and the two registers.
  logic [ENT_W-1:0]  heap_map [MAX_BLOCKS_DEF];
  logic [31:0]       base_cfg;
  logic [BIU_W-1:0]  blocks_cfg;

  reply_t            pending_replies[$];
  logic [31:0]       held_runs[$];
  reply_t            checked_reply;
  int                failures;
  int                sender_idle_pct;
  int                receiver_stall_pct;

  block_table_heap_allocator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("tb_block_table_heap_allocator failed");
    $finish;
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_replies.size() == 0) begin
        $error("unrequested result word: address %h status %b", m_axis_tdata_o,
               m_axis_tuser_o);
        failures++;
      end else begin
        checked_reply = pending_replies.pop_front();
        if (m_axis_tdata_o !== checked_reply.address) begin
          $error("address: expected %h, actual %h", checked_reply.address, m_axis_tdata_o);
          failures++;
        end
        if (m_axis_tuser_o !== checked_reply.status) begin
          $error("status: expected %b, actual %b", checked_reply.status, m_axis_tuser_o);
          failures++;
        end
      end
    end
  end

  function automatic int unsigned table_limit();
    return (blocks_cfg > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(blocks_cfg);
  endfunction

  // First fit: the lowest run of free entries that is long enough.
  function automatic reply_t predict_allocate(logic [31:0] bytes);
    reply_t      r;
    int unsigned lim;
    logic [32:0] need;
    int unsigned run;
    int unsigned start;
    bit          found;
    lim = table_limit();
    need = ({1'b0, bytes} + 33'(BLOCK_BYTES - 1)) >> BLOCK_SHIFT;
    r.address = '0;
    r.status = STATUS_NO_MEMORY;
    run = 0;
    start = 0;
    found = 1'b0;
    if (need == 0 || need > lim) return r;
    for (int unsigned i = 0; i < lim; i++) begin
      if (heap_map[i][ENT_TAKEN]) begin
        run = 0;
        continue;
      end
      if (run == 0) start = i;
      run++;
      if (run == need) begin
        found = 1'b1;
        break;
      end
    end
    if (!found) return r;
    for (int unsigned k = 0; k < need; k++) begin
      heap_map[start + k] = '0;
      heap_map[start + k][ENT_TAKEN] = 1'b1;
      heap_map[start + k][ENT_FIRST] = (k == 0);
      heap_map[start + k][ENT_NEXT] = (k + 1 < need);
    end
    r.address = base_cfg + 32'(start * BLOCK_BYTES);
    r.status = STATUS_OK;
    return r;
  endfunction

  function automatic void predict_free(logic [31:0] addr);
    int unsigned      lim;
    int unsigned      blk;
    logic [ENT_W-1:0] ent;
    lim = table_limit();
    if (addr < base_cfg) return;
    blk = (addr - base_cfg) >> BLOCK_SHIFT;
    for (int unsigned i = blk; i < lim; i++) begin
      ent = heap_map[i];
      heap_map[i] = '0;
      if (!ent[ENT_NEXT]) break;
    end
  endfunction

  // Called and returns at a falling edge.
  task automatic send_request(input logic op, input logic [31:0] bytes,
                              input logic [31:0] faddr);
    reply_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {faddr, bytes};
    s_axis_tuser_i = op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (op == OP_ALLOC) begin
      r = predict_allocate(bytes);
      if (r.status == STATUS_OK) held_runs.push_back(r.address);
    end else begin
      predict_free(faddr);
      r.address = '0;
      r.status = STATUS_OK;
    end
    pending_replies.push_back(r);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic allocate(input logic [31:0] bytes);
    send_request(OP_ALLOC, bytes, $urandom);
  endtask

  task automatic release_run(input logic [31:0] addr);
    send_request(OP_FREE, $urandom, addr);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_HEAP_BASE) begin
      base_cfg = value;
      held_runs.delete();
    end else begin
      blocks_cfg = value[BIU_W-1:0];
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Every request gives one word, so the block is idle once the last one is back.
  task automatic wait_idle();
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      1: begin
        sender_idle_pct = 72;
        receiver_stall_pct = 0;
      end
      2: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 72;
      end
      default: begin
        sender_idle_pct = 15;
        receiver_stall_pct = 15;
      end
    endcase
  endtask

  task automatic test_default_table();
    allocate(32'd0);
    allocate(32'hFFFF_FFFF);
    allocate(MAX_BLOCKS_DEF * BLOCK_BYTES + 1);
    allocate(32'd1);
    allocate(BLOCK_BYTES + 1);
    allocate(BLOCK_BYTES);
    release_run(32'h0000_1123);   // misaligned head of a two-block run
    release_run(32'h0000_2000);   // already free
    allocate(2 * BLOCK_BYTES);
    release_run(32'hFFFF_FFFF);   // far past the table
    release_run(32'h0000_0000);
    release_run(32'h0000_1000);
    release_run(32'h0000_3000);
    allocate(MAX_BLOCKS_DEF * BLOCK_BYTES);
    release_run(32'h0000_0000);
    wait_idle();
  endtask

  task automatic test_table_extremes();
    write_register(CFG_HEAP_BASE, 32'hFFFF_F000);
    write_register(CFG_BLOCKS_IN_USE, 32'd0);
    allocate(32'd1);
    release_run(32'hFFFF_F000);
    wait_idle();
    write_register(CFG_BLOCKS_IN_USE, 32'd2);
    allocate(BLOCK_BYTES);
    allocate(BLOCK_BYTES);        // address wraps to zero
    allocate(32'd1);
    release_run(32'h0000_0010);   // below the heap base
    wait_idle();
    write_register(CFG_BLOCKS_IN_USE, 32'h0000_07FF);
    allocate((MAX_BLOCKS_DEF - 2) * BLOCK_BYTES + 1);  // trailing run one block short
    allocate((MAX_BLOCKS_DEF - 2) * BLOCK_BYTES);
    wait_idle();
    // Shrink while the long run is still taken; its entries must be left alone.
    write_register(CFG_BLOCKS_IN_USE, 32'd1);
    release_run(32'h0000_1000);
    release_run(32'hFFFF_F000);
    allocate(32'd1);
    wait_idle();
    write_register(CFG_HEAP_BASE, 32'h0000_0000);
    write_register(CFG_BLOCKS_IN_USE, MAX_BLOCKS_DEF);
    release_run(32'h0000_0000);
    release_run(32'h0000_1000);
    release_run(32'h0000_2000);
    wait_idle();
  endtask

  task automatic random_request();
    int          pick;
    int          idx;
    logic [31:0] addr;
    logic [31:0] bytes;
    pick = $urandom_range(99);
    if (pick >= 45 && pick < 85 && held_runs.size() != 0) begin
      idx = $urandom_range(held_runs.size() - 1);
      addr = held_runs[idx];
      held_runs.delete(idx);
      if ($urandom_range(1)) addr = addr + $urandom_range(BLOCK_BYTES - 1);
      release_run(addr);
    end else if (pick >= 85) begin
      case ($urandom_range(2))
        0: addr = $urandom;
        1: addr = base_cfg + $urandom_range(table_limit() + 4) * BLOCK_BYTES
                  + $urandom_range(BLOCK_BYTES - 1);
        default: addr = base_cfg - 1 - $urandom_range(255);
      endcase
      release_run(addr);
    end else begin
      pick = $urandom_range(99);
      if (pick < 70) bytes = $urandom_range(6 * BLOCK_BYTES, 1);
      else if (pick < 80) bytes = $urandom_range(12, 1) * BLOCK_BYTES;
      else if (pick < 88) bytes = $urandom;
      else if (pick < 92) bytes = '0;
      else bytes = $urandom_range(table_limit(), 1) * BLOCK_BYTES
                   - $urandom_range(BLOCK_BYTES - 1);
      allocate(bytes);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned count;
    for (int p = 0; p < 8; p++) begin
      set_idling(0);
      if (p == 0) write_register(CFG_HEAP_BASE, 32'h0000_0000);
      else if (p == 5) write_register(CFG_HEAP_BASE, $urandom);
      else if (p == 6) write_register(CFG_HEAP_BASE, 32'hFFFF_0000);
      else write_register(CFG_HEAP_BASE, $urandom_range(32'hF_FFFF) << BLOCK_SHIFT);
      if (p == 7) write_register(CFG_BLOCKS_IN_USE, MAX_BLOCKS_DEF);
      else write_register(CFG_BLOCKS_IN_USE, $urandom_range(96, 8));
      set_idling(p % 4);
      count = (p == 7) ? 24 : 64;
      repeat (count) random_request();
      // Hand back what is still held so the next setting starts from a mostly clean map.
      while (held_runs.size() != 0) release_run(held_runs.pop_front());
      wait_idle();
    end
  endtask

  initial begin
    int unsigned drain;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    m_axis_tready_i = 1'b0;
    failures = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    base_cfg = '0;
    blocks_cfg = BIU_RESET;
    foreach (heap_map[i]) heap_map[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_table();
    test_table_extremes();
    test_random_traffic();

    drain = 0;
    while (pending_replies.size() != 0 && drain < FINAL_DRAIN_CYCLES) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (16) @(negedge clk_i);
    if (pending_replies.size() != 0) begin
      $error("%0d result words never arrived", pending_replies.size());
      failures++;
    end
    if (failures == 0) begin
      $display("tb_block_table_heap_allocator passed");
    end else begin
      $display("tb_block_table_heap_allocator failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/bta_pkg.sv
hdl/bta_ctrl.sv
hdl/bta_dpath.sv
hdl/block_table_heap_allocator.sv
hdl/bta_checker.sv
sim/tb_block_table_heap_allocator.sv
